// ===== rtl/core/nt2d_pkg.sv =====
// package for number_to_text_digits: modes, fsm states, character codes
`default_nettype none

package nt2d_pkg;

  // radix modes carried in the command field
  typedef enum logic [1:0] {
    CMD_UDEC = 2'd0,
    CMD_SDEC = 2'd1,
    CMD_HEX  = 2'd2,
    CMD_BIN  = 2'd3
  } cmd_e;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_CONV  = 2'd1,
    ST_ALIGN = 2'd2,
    ST_EMIT  = 2'd3
  } state_e;

  // ascii codes
  localparam logic [6:0] CH_ZERO     = 7'h30;
  localparam logic [6:0] CH_LETTER_A = 7'h41;
  localparam logic [6:0] CH_PLUS     = 7'h2B;
  localparam logic [6:0] CH_MINUS    = 7'h2D;

  // digit count limits per mode
  localparam logic [5:0] MAXD_DEC = 6'd10;
  localparam logic [5:0] MAXD_HEX = 6'd8;
  localparam logic [5:0] MAXD_BIN = 6'd32;

  // panel size defaults in pixels
  localparam int unsigned DISPLAY_WIDTH_DEF  = 128;
  localparam int unsigned DISPLAY_HEIGHT_DEF = 64;

endpackage

`default_nettype wire

// ===== rtl/core/number_to_text_digits.sv =====
// number to ascii text converter, one character transaction per digit, plus a sign in signed decimal mode
//
// channel  direction  signals                      payload
// s_axis   in         tvalid tready tdata[47:0]    command, value, digit_count,
//                                                  text_line, first_column
// m_axis   out        tvalid tready tdata[15:0]    char_code, out_line, out_column
//                     tuser[0] tlast               on_screen, last_char
//
// sequence: decimal modes run bit-serial double dabble, then
//   (10 - digits) alignment shifts; hex takes (8 - digits), binary (32 - digits)
//   alignment shifts; then each character (a sign in signed decimal mode, then the
//   digits) is loaded into the output register whenever it is free.
// one number is processed at a time; the next one is taken once the last
// character sits in the output register.
// reset is asynchronous active low and returns the sequencer to idle.
// a stalled output register holds the sequencer in the emit state.
`default_nettype none

module number_to_text_digits
  import nt2d_pkg::*;
#(
  parameter int unsigned DISPLAY_WIDTH  = DISPLAY_WIDTH_DEF,
  parameter int unsigned DISPLAY_HEIGHT = DISPLAY_HEIGHT_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // command[1:0], value[33:2], digit_count[39:34], text_line[42:40],
  // first_column[47:43]
  input  wire logic [47:0] s_axis_tdata_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // char_code[6:0], out_line[9:7], out_column[15:10]
  output logic [15:0]      m_axis_tdata_o,
  // on_screen[0]
  output logic [0:0]       m_axis_tuser_o,
  output logic             m_axis_tlast_o
);

  localparam int unsigned LINE_LIM = DISPLAY_HEIGHT / 8;
  localparam int unsigned COL_LIM  = DISPLAY_WIDTH;

  state_e      state_q, state_d;
  cmd_e        mode_q, mode_d;
  logic [39:0] sr_q, sr_d;          // bcd / digit shift register
  logic [31:0] bin_q, bin_d;        // binary source for double dabble
  logic [4:0]  bit_cnt_q, bit_cnt_d;
  logic [4:0]  skip_q, skip_d;
  logic [5:0]  remain_q, remain_d;
  logic        sign_pend_q, sign_pend_d;
  logic        neg_q, neg_d;
  logic [2:0]  line_q, line_d;
  logic [5:0]  col_q, col_d;

  logic        out_valid_q, out_valid_d;
  logic [6:0]  out_code_q, out_code_d;
  logic [2:0]  out_line_q, out_line_d;
  logic [5:0]  out_col_q, out_col_d;
  logic        out_vis_q, out_vis_d;
  logic        out_last_q, out_last_d;

  // input fields
  cmd_e        in_cmd;
  logic [31:0] in_value;
  logic [5:0]  in_count;
  logic [2:0]  in_line;
  logic [4:0]  in_col;
  logic [5:0]  maxd;
  logic [5:0]  cnt_clamp;
  logic        in_neg;
  logic        s_hs;
  logic        out_free;

  // datapath helpers
  logic [39:0] dabble;
  logic [3:0]  top_digit;
  logic [6:0]  digit_code;
  logic        cell_vis;
  logic [31:0] line_ext;
  logic [31:0] col_ext;

  assign in_cmd   = cmd_e'(s_axis_tdata_i[1:0]);
  assign in_value = s_axis_tdata_i[33:2];
  assign in_count = s_axis_tdata_i[39:34];
  assign in_line  = s_axis_tdata_i[42:40];
  assign in_col   = s_axis_tdata_i[47:43];
  assign in_neg   = (in_cmd == CMD_SDEC) && in_value[31];

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign s_hs            = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_valid_q || m_axis_tready_i;

  // digit count clamp per mode
  always_comb begin
    unique case (in_cmd)
      CMD_HEX: maxd = MAXD_HEX;
      CMD_BIN: maxd = MAXD_BIN;
      default: maxd = MAXD_DEC;
    endcase
    if (in_count == 6'd0) begin
      cnt_clamp = 6'd1;
    end else if (in_count > maxd) begin
      cnt_clamp = maxd;
    end else begin
      cnt_clamp = in_count;
    end
  end

  // add-3 correction on each bcd digit before the shift
  always_comb begin
    for (int i = 0; i < 10; i++) begin
      if (sr_q[4*i +: 4] >= 4'd5) begin
        dabble[4*i +: 4] = sr_q[4*i +: 4] + 4'd3;
      end else begin
        dabble[4*i +: 4] = sr_q[4*i +: 4];
      end
    end
  end

  // top digit of the shift register and its character
  always_comb begin
    if (mode_q == CMD_BIN) begin
      top_digit = {3'b000, sr_q[39]};
    end else begin
      top_digit = sr_q[39:36];
    end
    if (top_digit < 4'd10) begin
      digit_code = CH_ZERO + {3'b000, top_digit};
    end else begin
      digit_code = CH_LETTER_A + {3'b000, top_digit} - 7'd10;
    end
  end

  // on-screen check of the current cell
  always_comb begin
    line_ext = {29'd0, line_q};
    col_ext  = {26'd0, col_q};
    cell_vis = (line_q != 3'd0) && (col_q != 6'd0) &&
               ((((line_ext - 32'd1) << 1) + 32'd1) < 32'(LINE_LIM)) &&
               (((col_ext - 32'd1) << 3) < 32'(COL_LIM));
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_hs) begin
          if (in_cmd == CMD_HEX || in_cmd == CMD_BIN) begin
            state_d = ST_ALIGN;
          end else begin
            state_d = ST_CONV;
          end
        end
      end
      ST_CONV: begin
        if (bit_cnt_q == 5'd31) begin
          state_d = ST_ALIGN;
        end
      end
      ST_ALIGN: begin
        if (skip_q == 5'd0) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free && !sign_pend_q && remain_q == 6'd1) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and output register next values
  always_comb begin
    mode_d      = mode_q;
    sr_d        = sr_q;
    bin_d       = bin_q;
    bit_cnt_d   = bit_cnt_q;
    skip_d      = skip_q;
    remain_d    = remain_q;
    sign_pend_d = sign_pend_q;
    neg_d       = neg_q;
    line_d      = line_q;
    col_d       = col_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_code_d  = out_code_q;
    out_line_d  = out_line_q;
    out_col_d   = out_col_q;
    out_vis_d   = out_vis_q;
    out_last_d  = out_last_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_hs) begin
          mode_d      = in_cmd;
          neg_d       = in_neg;
          sign_pend_d = (in_cmd == CMD_SDEC);
          bin_d       = in_neg ? (32'd0 - in_value) : in_value;
          sr_d        = {in_value, 8'd0};
          bit_cnt_d   = 5'd0;
          skip_d      = 5'(maxd - cnt_clamp);
          remain_d    = cnt_clamp;
          line_d      = in_line;
          col_d       = {1'b0, in_col};
          if (in_cmd != CMD_HEX && in_cmd != CMD_BIN) begin
            sr_d = 40'd0;
          end
        end
      end
      ST_CONV: begin
        sr_d      = {dabble[38:0], bin_q[31]};
        bin_d     = {bin_q[30:0], 1'b0};
        bit_cnt_d = bit_cnt_q + 5'd1;
      end
      ST_ALIGN: begin
        if (skip_q != 5'd0) begin
          skip_d = skip_q - 5'd1;
          if (mode_q == CMD_BIN) begin
            sr_d = {sr_q[38:0], 1'b0};
          end else begin
            sr_d = {sr_q[35:0], 4'd0};
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_line_d  = line_q;
          out_col_d   = col_q;
          out_vis_d   = cell_vis;
          col_d       = col_q + 6'd1;
          if (sign_pend_q) begin
            sign_pend_d = 1'b0;
            out_code_d  = neg_q ? CH_MINUS : CH_PLUS;
            out_last_d  = 1'b0;
          end else begin
            out_code_d = digit_code;
            out_last_d = (remain_q == 6'd1);
            remain_d   = remain_q - 6'd1;
            if (mode_q == CMD_BIN) begin
              sr_d = {sr_q[38:0], 1'b0};
            end else begin
              sr_d = {sr_q[35:0], 4'd0};
            end
          end
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      sign_pend_q <= 1'b0;
      remain_q    <= 6'd0;
      skip_q      <= 5'd0;
      bit_cnt_q   <= 5'd0;
      mode_q      <= CMD_UDEC;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      sign_pend_q <= sign_pend_d;
      remain_q    <= remain_d;
      skip_q      <= skip_d;
      bit_cnt_q   <= bit_cnt_d;
      mode_q      <= mode_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    sr_q       <= sr_d;
    bin_q      <= bin_d;
    neg_q      <= neg_d;
    line_q     <= line_d;
    col_q      <= col_d;
    out_code_q <= out_code_d;
    out_line_q <= out_line_d;
    out_col_q  <= out_col_d;
    out_vis_q  <= out_vis_d;
    out_last_q <= out_last_d;
  end

  // output transaction
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_col_q, out_line_q, out_code_q};
  assign m_axis_tuser_o  = out_vis_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

`default_nettype wire
